@@ src/rbsq_pkg.sv @@
// rain burst sample qualifier: shared constants, codes and types
// no dependencies; imported by every module of the block
`default_nettype none

package rbsq_pkg;

  // sizing
  localparam int unsigned MAX_PROBES    = 4;
  localparam int unsigned HISTORY_DEPTH = 6;
  localparam int unsigned DATA_W        = 16;
  localparam int unsigned CNT_W         = $clog2(MAX_PROBES + 1);
  localparam int unsigned SUM_W         = DATA_W + $clog2(MAX_PROBES);
  localparam int unsigned STEP_W        = $clog2(SUM_W + 1);
  localparam int unsigned NUM_LANES     = 3;
  localparam int unsigned ADDR_W        = 4;
  localparam int unsigned PDATA_W       = 32;

  // divider lanes
  localparam int unsigned LANE_BEFORE = 0;
  localparam int unsigned LANE_BURST  = 1;
  localparam int unsigned LANE_AFTER  = 2;

  // result status codes
  localparam logic [2:0] STS_OK    = 3'd0;
  localparam logic [2:0] STS_GAP   = 3'd1;
  localparam logic [2:0] STS_LOW   = 3'd2;
  localparam logic [2:0] STS_STEP  = 3'd3;
  localparam logic [2:0] STS_OTHER = 3'd4;

  // source codes
  localparam logic [1:0] CH_A = 2'd0;
  localparam logic [1:0] CH_B = 2'd1;

  // register indexes
  localparam logic [1:0] REG_GAP_LIMIT  = 2'd0;
  localparam logic [1:0] REG_CALIBRATED = 2'd1;
  localparam logic [1:0] REG_MIN_BURST  = 2'd2;
  localparam logic [1:0] REG_STEP_LIMIT = 2'd3;

  // register reset values
  localparam logic [DATA_W-1:0] RST_GAP_LIMIT  = 16'd1000;
  localparam logic              RST_CALIBRATED = 1'b0;
  localparam logic [DATA_W-1:0] RST_MIN_BURST  = 16'd34000;
  localparam logic [DATA_W-1:0] RST_STEP_LIMIT = 16'd250;

  typedef struct packed {
    logic [DATA_W-1:0] gap_limit;
    logic              calibrated;
    logic [DATA_W-1:0] min_burst;
    logic [DATA_W-1:0] dc_step_limit;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture input word
    logic accum;     // add probe into group sums
    logic clear;     // clear group sums and count
    logic div_init;  // load dividers from sums
    logic div_step;  // one quotient bit on every lane
    logic finish;    // channel decision and result
    logic reject;    // probe rejected result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic gap_fail;
    logic burst_low;
    logic group_end;
  } sts_t;

  function automatic logic [DATA_W-1:0] abs_gap(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

@@ src/rbsq_regs.sv @@
// configuration register file behind the apb-style port
// depends on rbsq_pkg
`default_nettype none

module rbsq_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rbsq_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rbsq_pkg::PDATA_W-1:0] pwdata,
  output logic      [rbsq_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  output rbsq_pkg::cfg_t                    cfg_o
);
  import rbsq_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_GAP_LIMIT:  cfg_d.gap_limit     = pwdata[DATA_W-1:0];
        REG_CALIBRATED: cfg_d.calibrated    = pwdata[0];
        REG_MIN_BURST:  cfg_d.min_burst     = pwdata[DATA_W-1:0];
        REG_STEP_LIMIT: cfg_d.dc_step_limit = pwdata[DATA_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_limit     <= RST_GAP_LIMIT;
      cfg_q.calibrated    <= RST_CALIBRATED;
      cfg_q.min_burst     <= RST_MIN_BURST;
      cfg_q.dc_step_limit <= RST_STEP_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_GAP_LIMIT:  prdata = PDATA_W'(cfg_q.gap_limit);
      REG_CALIBRATED: prdata = PDATA_W'(cfg_q.calibrated);
      REG_MIN_BURST:  prdata = PDATA_W'(cfg_q.min_burst);
      REG_STEP_LIMIT: prdata = PDATA_W'(cfg_q.dc_step_limit);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ src/rbsq_ctrl.sv @@
// sequencing state machine: probe checks, group sums, division, result
// depends on rbsq_pkg
`default_nettype none

module rbsq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  rbsq_pkg::sts_t     sts_i,
  output rbsq_pkg::cmd_t     cmd_o
);
  import rbsq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_DINIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  // next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.gap_fail || sts_i.burst_low) begin
          cmd_o.reject = 1'b1;
          cmd_o.clear  = 1'b1;
          state_d      = S_OUT;
        end else begin
          cmd_o.accum = 1'b1;
          state_d     = sts_i.group_end ? S_DINIT : S_IDLE;
        end
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        cmd_o.clear    = 1'b1;
        step_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

@@ src/rbsq_dp.sv @@
// datapath: input capture, probe checks, group sums, bit-serial dividers,
// per-channel dc tracking and burst history; depends on rbsq_pkg
`default_nettype none

module rbsq_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  rbsq_pkg::cfg_t                   cfg_i,
  input  rbsq_pkg::cmd_t                   cmd_i,
  output rbsq_pkg::sts_t                   sts_o,
  input  wire logic [1:0]                  channel_i,
  input  wire logic [rbsq_pkg::DATA_W-1:0] dc_before_i,
  input  wire logic [rbsq_pkg::DATA_W-1:0] burst_level_i,
  input  wire logic [rbsq_pkg::DATA_W-1:0] dc_after_i,
  input  wire logic                        last_probe_i,
  output logic      [rbsq_pkg::DATA_W-1:0] value_o,
  output logic      [2:0]                  status_o
);
  import rbsq_pkg::*;

  // captured word
  logic [1:0]        ch_q;
  logic [DATA_W-1:0] before_q, burst_q, after_q;
  logic              last_q;

  // group state
  logic [SUM_W-1:0]  sum_q [NUM_LANES];
  logic [CNT_W-1:0]  cnt_q;

  // dividers
  logic [SUM_W-1:0]  dvd_q [NUM_LANES];
  logic [SUM_W-1:0]  dvd_nx [NUM_LANES];
  logic [CNT_W-1:0]  rem_q [NUM_LANES];
  logic [CNT_W-1:0]  rem_nx [NUM_LANES];
  logic [CNT_W-1:0]  div_q;

  // channel tracking
  logic [DATA_W-1:0] prev_a_q [2];
  logic [DATA_W-1:0] prev_b_q [2];
  logic [DATA_W-1:0] hist_a_q [HISTORY_DEPTH];
  logic [DATA_W-1:0] hist_b_q [HISTORY_DEPTH];

  logic [DATA_W-1:0] value_q;
  logic [2:0]        status_q;

  logic [DATA_W-1:0] avg_before, avg_burst, avg_after;
  logic [DATA_W-1:0] prev0, prev1;
  logic              is_led, step_ok;

  // probe checks on the captured word
  assign sts_o.gap_fail  = cfg_i.calibrated &&
                           (abs_gap(after_q, before_q) >= cfg_i.gap_limit);
  assign sts_o.burst_low = (burst_q <= cfg_i.min_burst);
  assign sts_o.group_end = last_q || (cnt_q == CNT_W'(MAX_PROBES - 1));

  // one restoring division step per lane
  always_comb begin
    logic [CNT_W:0] trial;
    logic           ge;
    for (int l = 0; l < NUM_LANES; l++) begin
      trial     = {rem_q[l], dvd_q[l][SUM_W-1]};
      ge        = (trial >= {1'b0, div_q});
      rem_nx[l] = ge ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
      dvd_nx[l] = {dvd_q[l][SUM_W-2:0], ge};
    end
  end

  // averages and dc step check
  assign avg_before = dvd_q[LANE_BEFORE][DATA_W-1:0];
  assign avg_burst  = dvd_q[LANE_BURST][DATA_W-1:0];
  assign avg_after  = dvd_q[LANE_AFTER][DATA_W-1:0];
  assign is_led     = (ch_q == CH_A) || (ch_q == CH_B);
  assign prev0      = (ch_q == CH_A) ? prev_a_q[0] : prev_b_q[0];
  assign prev1      = (ch_q == CH_A) ? prev_a_q[1] : prev_b_q[1];
  assign step_ok    = (abs_gap(prev0, avg_before) <= cfg_i.dc_step_limit) &&
                      (abs_gap(prev1, avg_after) <= cfg_i.dc_step_limit);

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q     <= channel_i;
      before_q <= dc_before_i;
      burst_q  <= burst_level_i;
      after_q  <= dc_after_i;
      last_q   <= last_probe_i;
    end
  end

  // group sums and probe count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LANES; l++) sum_q[l] <= '0;
      cnt_q <= '0;
    end else if (cmd_i.clear) begin
      for (int l = 0; l < NUM_LANES; l++) sum_q[l] <= '0;
      cnt_q <= '0;
    end else if (cmd_i.accum) begin
      sum_q[LANE_BEFORE] <= sum_q[LANE_BEFORE] + SUM_W'(before_q);
      sum_q[LANE_BURST]  <= sum_q[LANE_BURST] + SUM_W'(burst_q);
      sum_q[LANE_AFTER]  <= sum_q[LANE_AFTER] + SUM_W'(after_q);
      cnt_q              <= cnt_q + CNT_W'(1);
    end
  end

  // divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        dvd_q[l] <= sum_q[l];
        rem_q[l] <= '0;
      end
      div_q <= cnt_q;
    end else if (cmd_i.div_step) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        dvd_q[l] <= dvd_nx[l];
        rem_q[l] <= rem_nx[l];
      end
    end
  end

  // previous dc levels and burst history per channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 2; k++) begin
        prev_a_q[k] <= '0;
        prev_b_q[k] <= '0;
      end
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_a_q[k] <= '0;
        hist_b_q[k] <= '0;
      end
    end else if (cmd_i.finish) begin
      if (ch_q == CH_A) begin
        prev_a_q[0] <= avg_before;
        prev_a_q[1] <= avg_after;
        if (step_ok) begin
          for (int k = HISTORY_DEPTH - 1; k > 0; k--) hist_a_q[k] <= hist_a_q[k-1];
          hist_a_q[0] <= avg_burst;
        end
      end else if (ch_q == CH_B) begin
        prev_b_q[0] <= avg_before;
        prev_b_q[1] <= avg_after;
        if (step_ok) begin
          for (int k = HISTORY_DEPTH - 1; k > 0; k--) hist_b_q[k] <= hist_b_q[k-1];
          hist_b_q[0] <= avg_burst;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.reject) begin
      value_q  <= '0;
      status_q <= sts_o.gap_fail ? STS_GAP : STS_LOW;
    end else if (cmd_i.finish) begin
      if (!is_led) begin
        value_q  <= avg_burst;
        status_q <= STS_OTHER;
      end else if (step_ok) begin
        value_q  <= avg_burst;
        status_q <= STS_OK;
      end else begin
        value_q  <= '0;
        status_q <= STS_STEP;
      end
    end
  end

  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

@@ src/rain_burst_sample_qualifier.sv @@
// top level of the rain burst sample qualifier
// depends on rbsq_pkg, rbsq_regs, rbsq_ctrl, rbsq_dp
`default_nettype none

// Takes one probe word (dc before, burst, dc after) at a time and answers a
// group of up to four probes with one result word. A probe that is summed but
// does not close its group gives no result word; a rejected probe (dc gap or
// low burst) gives its result word after the check; a probe that closes a
// group gives its result after capture, check, divider load, 18 steps of the
// bit-serial dividers that average the three sums (one quotient bit per cycle,
// one per sum width bit), and the channel decision. The input is ready again
// in the cycle after the result word is taken, or after the check of a probe
// that is summed but does not close its group, so one word is in flight at a
// time. Configuration writes take effect at once and belong in idle periods.

module rain_burst_sample_qualifier (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rbsq_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rbsq_pkg::PDATA_W-1:0] pwdata,
  output logic      [rbsq_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  // probe words
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   channel_i,
  input  wire logic [rbsq_pkg::DATA_W-1:0]  dc_before_i,
  input  wire logic [rbsq_pkg::DATA_W-1:0]  burst_level_i,
  input  wire logic [rbsq_pkg::DATA_W-1:0]  dc_after_i,
  input  wire logic                         last_probe_i,
  // result words
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [rbsq_pkg::DATA_W-1:0]  value_o,
  output logic      [2:0]                   status_o
);
  import rbsq_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  rbsq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rbsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rbsq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .channel_i     (channel_i),
    .dc_before_i   (dc_before_i),
    .burst_level_i (burst_level_i),
    .dc_after_i    (dc_after_i),
    .last_probe_i  (last_probe_i),
    .value_o       (value_o),
    .status_o      (status_o)
  );

  // one word in flight: never ready for input while a result is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while result pending");

  // a taken result word is not shown again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("result word repeated");

  // rejected results carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STS_GAP || status_o == STS_LOW ||
                    status_o == STS_STEP) |-> value_o == '0)
    else $error("nonzero value on rejected result");

  // an accepted probe never yields a result in the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result before probe evaluation");

endmodule

`default_nettype wire

@@ sim/rain_burst_sample_qualifier_tb.sv @@
// testbench for the rain burst sample qualifier: directed probe groups, then
// random groups under several register settings, checked by a built-in predictor
// depends on rbsq_pkg and rain_burst_sample_qualifier

module rain_burst_sample_qualifier_tb;
  import rbsq_pkg::*;

  localparam int          SETTLE      = 40;
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [1:0]  CH_OTHER    = 2'd2;
  localparam logic [1:0]  CH_SPARE    = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [2:0]        status;
  } verdict_t;

  // predictor of the group verdicts plus the queue of verdicts still owed
  class burst_verdicts;
    cfg_t              cfg;
    logic [SUM_W-1:0]  sum_before, sum_burst, sum_after;
    logic [CNT_W-1:0]  n_probes;
    logic [DATA_W-1:0] last_dc [2][2];
    logic [DATA_W-1:0] accepted [2][HISTORY_DEPTH];
    verdict_t          verdicts_due[$];
    int                mismatches;

    function new();
      cfg.gap_limit     = RST_GAP_LIMIT;
      cfg.calibrated    = RST_CALIBRATED;
      cfg.min_burst     = RST_MIN_BURST;
      cfg.dc_step_limit = RST_STEP_LIMIT;
      drop_group();
      for (int c = 0; c < 2; c++) begin
        last_dc[c][0] = '0;
        last_dc[c][1] = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++) accepted[c][k] = '0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
      case (idx)
        REG_GAP_LIMIT:  cfg.gap_limit = data[DATA_W-1:0];
        REG_CALIBRATED: cfg.calibrated = data[0];
        REG_MIN_BURST:  cfg.min_burst = data[DATA_W-1:0];
        REG_STEP_LIMIT: cfg.dc_step_limit = data[DATA_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] spread(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function void drop_group();
      sum_before = '0;
      sum_burst  = '0;
      sum_after  = '0;
      n_probes   = '0;
    endfunction

    function void owe(input logic [DATA_W-1:0] value, input logic [2:0] status);
      verdict_t v;
      v.value  = value;
      v.status = status;
      verdicts_due.push_back(v);
    endfunction

    // one accepted probe word
    function void take_probe(input logic [1:0] ch, input logic [DATA_W-1:0] dc_pre,
                             input logic [DATA_W-1:0] level, input logic [DATA_W-1:0] after,
                             input logic closing);
      logic [DATA_W-1:0] avg_before, avg_burst, avg_after, drift_before, drift_after;
      int                lane;
      // per-probe rejects, gap check first
      if (cfg.calibrated && spread(after, dc_pre) >= cfg.gap_limit) begin
        drop_group();
        owe('0, STS_GAP);
        return;
      end
      if (level <= cfg.min_burst) begin
        drop_group();
        owe('0, STS_LOW);
        return;
      end
      sum_before += SUM_W'(dc_pre);
      sum_burst  += SUM_W'(level);
      sum_after  += SUM_W'(after);
      n_probes++;
      if (!closing && n_probes < MAX_PROBES) return;
      // group closes: truncating averages
      avg_before = DATA_W'(sum_before / n_probes);
      avg_burst  = DATA_W'(sum_burst / n_probes);
      avg_after  = DATA_W'(sum_after / n_probes);
      drop_group();
      if (ch == CH_A || ch == CH_B) begin
        lane = (ch == CH_B) ? 1 : 0;
        drift_before = spread(last_dc[lane][0], avg_before);
        drift_after  = spread(last_dc[lane][1], avg_after);
        last_dc[lane][0] = avg_before;
        last_dc[lane][1] = avg_after;
        if (drift_before > cfg.dc_step_limit || drift_after > cfg.dc_step_limit) begin
          owe('0, STS_STEP);
        end else begin
          for (int k = HISTORY_DEPTH - 1; k > 0; k--) accepted[lane][k] = accepted[lane][k-1];
          accepted[lane][0] = avg_burst;
          owe(avg_burst, STS_OK);
        end
      end else begin
        owe(avg_burst, STS_OTHER);
      end
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    // one accepted result word against the oldest verdict owed
    task match_verdict(input logic [DATA_W-1:0] value, input logic [2:0] status);
      verdict_t want;
      string    why;
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word value %0d status %0d", value, status));
        return;
      end
      want = verdicts_due.pop_front();
      why = "";
      if (value !== want.value)
        why = {why, $sformatf(" value %0d/%0d", value, want.value)};
      if (status !== want.status)
        why = {why, $sformatf(" status %0d/%0d", status, want.status)};
      if (why != "") report_mismatch({"got/expected:", why});
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel, penable, pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]  pwdata, prdata;
  logic                pready;
  logic                in_valid_i, in_ready_o;
  logic [1:0]          channel_i;
  logic [DATA_W-1:0]   dc_before_i, burst_level_i, dc_after_i;
  logic                last_probe_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [DATA_W-1:0]   value_o;
  logic [2:0]          status_o;

  logic [31:0]         cycles = '0;
  int                  burst_left = 0;
  logic [DATA_W-1:0]   lvl_before [4];
  logic [DATA_W-1:0]   lvl_after [4];
  burst_verdicts       verdicts = new();

  rain_burst_sample_qualifier DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .channel_i     (channel_i),
    .dc_before_i   (dc_before_i),
    .burst_level_i (burst_level_i),
    .dc_after_i    (dc_after_i),
    .last_probe_i  (last_probe_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .status_o      (status_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycle count and watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rain_burst_sample_qualifier_tb failed");
      $finish;
    end
  end

  // result side: stall pattern chosen by bits 9:8 of the cycle count
  always @(negedge clk_i) begin
    case (cycles[9:8])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= 1'($urandom_range(0, 1));
      2'd2:    out_ready_i <= (cycles[1:0] == 2'b11);
      default: out_ready_i <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) verdicts.match_verdict(value_o, status_o);
  end

  // probe side held idle, for a time set by n
  task automatic hold_off(input int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // bursts of words with random gaps between them
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
    end
    burst_left--;
  endtask

  task automatic send_probe(input logic [1:0] ch, input logic [DATA_W-1:0] dc_pre,
                            input logic [DATA_W-1:0] level, input logic [DATA_W-1:0] after,
                            input logic closing);
    pace();
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    channel_i     <= ch;
    dc_before_i   <= dc_pre;
    burst_level_i <= level;
    dc_after_i    <= after;
    last_probe_i  <= closing;
    do @(posedge clk_i); while (!in_ready_o);
    verdicts.take_probe(ch, dc_pre, level, after, closing);
  endtask

  // stop sending until every owed verdict is in
  task automatic drain();
    hold_off(1);
    while (verdicts.verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    verdicts.write_reg(idx, data);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // registers change only with the block idle
  task automatic set_config(input int gap_max, input int cal, input int burst_min,
                            input int step_max);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    reg_write(REG_GAP_LIMIT, gap_max);
    reg_write(REG_CALIBRATED, cal);
    reg_write(REG_MIN_BURST, burst_min);
    reg_write(REG_STEP_LIMIT, step_max);
  endtask

  function automatic logic [DATA_W-1:0] near(input logic [DATA_W-1:0] c, input int span);
    int v;
    v = $urandom_range(0, 2 * span);
    v = v - span;
    v = v + int'(c);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return DATA_W'(v);
  endfunction

  function automatic logic [DATA_W-1:0] strong_burst();
    int lo;
    lo = int'(verdicts.cfg.min_burst);
    if (lo >= 65535) return DATA_W'($urandom);
    return DATA_W'($urandom_range(lo + 1, 65535));
  endfunction

  function automatic logic [1:0] pick_channel();
    int r;
    r = $urandom_range(0, 7);
    if (r < 3) return CH_A;
    if (r < 6) return CH_B;
    if (r == 6) return CH_OTHER;
    return CH_SPARE;
  endfunction

  // corner cases under reset settings, then with the gap check on
  task automatic probe_corner_cases();
    send_probe(CH_A, 0, 65535, 0, 1'b1);
    send_probe(CH_A, 0, 34000, 0, 1'b1);
    send_probe(CH_A, 100, 34001, 200, 1'b1);
    // four unmarked probes close the group on their own
    send_probe(CH_B, 10, 40000, 0, 1'b0);
    send_probe(CH_B, 20, 40001, 0, 1'b0);
    send_probe(CH_B, 30, 40002, 0, 1'b0);
    send_probe(CH_B, 41, 40004, 0, 1'b0);
    send_probe(CH_OTHER, 65535, 65535, 65535, 1'b1);
    send_probe(CH_SPARE, 1, 50000, 1, 1'b1);
    // dc step rejected, then steady against the updated levels
    send_probe(CH_A, 60000, 50000, 60000, 1'b1);
    send_probe(CH_A, 60000, 50000, 60000, 1'b1);
    // mixed sources: the closing probe decides
    send_probe(CH_A, 60000, 40000, 60000, 1'b0);
    send_probe(CH_OTHER, 0, 36000, 0, 1'b1);
    // low burst in mid group clears it
    send_probe(CH_B, 25, 45000, 0, 1'b0);
    send_probe(CH_B, 25, 1000, 0, 1'b0);
    send_probe(CH_B, 25, 45000, 0, 1'b1);
    // truncating average
    send_probe(CH_B, 25, 40000, 0, 1'b0);
    send_probe(CH_B, 25, 40001, 0, 1'b0);
    send_probe(CH_B, 25, 40001, 0, 1'b1);
    set_config(1000, 1, 34000, 250);
    send_probe(CH_A, 60000, 50000, 61000, 1'b1);
    send_probe(CH_A, 60000, 50000, 60999, 1'b1);
    send_probe(CH_A, 0, 0, 65535, 1'b1);
    send_probe(CH_A, 65535, 65535, 65535, 1'b1);
    send_probe(CH_OTHER, 65535, 65535, 64536, 1'b1);
  endtask

  // random groups: mostly steady ones, some noise and broken groups
  task automatic play_groups(input int quota);
    int                sent, len, kind, flaw, jit, lo;
    logic [1:0]        ch;
    logic [DATA_W-1:0] dc_pre, level, after;
    logic              closing;
    bit                mid_drained;
    sent = 0;
    mid_drained = 1'b0;
    for (int c = 0; c < 4; c++) begin
      lvl_before[c] = DATA_W'($urandom);
      lvl_after[c]  = near(lvl_before[c], 300);
    end
    while (sent < quota) begin
      kind = $urandom_range(0, 9);
      ch = pick_channel();
      if ($urandom_range(0, 7) == 0) begin
        lvl_before[ch] = DATA_W'($urandom);
        lvl_after[ch]  = near(lvl_before[ch], 300);
      end
      len  = $urandom_range(1, MAX_PROBES + 1);
      flaw = (kind == 8) ? $urandom_range(0, len - 1) : -1;
      jit  = ($urandom_range(0, 3) == 0) ? 0 : 40;
      for (int k = 0; k < len; k++) begin
        if (kind == 7) begin
          ch      = 2'($urandom);
          dc_pre  = DATA_W'($urandom);
          level   = DATA_W'($urandom);
          after   = DATA_W'($urandom);
          closing = 1'($urandom);
        end else begin
          if (kind == 9) ch = 2'($urandom);
          dc_pre  = near(lvl_before[ch], jit);
          after   = near(lvl_after[ch], jit);
          level   = strong_burst();
          closing = (k == len - 1) && ($urandom_range(0, 3) != 0);
          if (k == flaw) begin
            lo = int'(verdicts.cfg.min_burst);
            if ($urandom_range(0, 1)) level = DATA_W'($urandom_range(0, lo));
            else after = dc_pre ^ 16'h8000;
          end
        end
        send_probe(ch, dc_pre, level, after, closing);
        sent++;
        if (!mid_drained && sent >= quota / 2) begin
          drain();
          mid_drained = 1'b1;
        end
      end
    end
  endtask

  // main sequence
  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    channel_i     = '0;
    dc_before_i   = '0;
    burst_level_i = '0;
    dc_after_i    = '0;
    last_probe_i  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    probe_corner_cases();
    set_config(2000, 1, 34000, 250);
    play_groups(110);
    set_config(65535, 0, 0, 65535);
    play_groups(80);
    set_config(65535, 1, 20000, 0);
    play_groups(70);
    set_config(0, 1, 34000, 250);
    play_groups(15);
    set_config(1000, 0, 65535, 250);
    play_groups(15);
    set_config(500, 1, 30000, 1000);
    play_groups(110);

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (verdicts.mismatches == 0) begin
      $display("rain_burst_sample_qualifier_tb passed");
    end else begin
      $display("rain_burst_sample_qualifier_tb failed");
    end
    $finish;
  end

endmodule

@@ rain_burst_sample_qualifier.f @@
src/rbsq_pkg.sv
src/rbsq_regs.sv
src/rbsq_ctrl.sv
src/rbsq_dp.sv
src/rain_burst_sample_qualifier.sv
sim/rain_burst_sample_qualifier_tb.sv
